FILE: sv/rtc_pkg.sv
package rtc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int INDEX_WIDTH_DEF = 24;

  localparam int NUM_UOPS = 24;
  localparam int STEP_W   = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
    REG_DIR_X, REG_DIR_Y, REG_DIR_Z,
    REG_T_NEAR, REG_T_FAR
  } cfg_reg_t;

  typedef enum logic [3:0] {
    A_D0, A_D1, A_D2, A_S0, A_S1, A_S2,
    A_H0, A_H1, A_H2, A_Q0, A_Q1, A_Q2
  } asel_t;

  typedef enum logic [3:0] {
    B_D0, B_D1, B_D2, B_E10, B_E11, B_E12,
    B_E20, B_E21, B_E22, B_S0, B_S1, B_S2
  } bsel_t;

  typedef enum logic [3:0] {
    R_H0, R_H1, R_H2, R_Q0, R_Q1, R_Q2, R_A, R_UN, R_VN, R_TN
  } rsel_t;

  typedef struct packed {
    asel_t a;
    bsel_t b;
    logic  neg;
    logic  first;
    logic  last;
    rsel_t dst;
  } uop_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_ctl_t;

  function automatic uop_t mk(input asel_t a, input bsel_t b, input logic neg,
                              input logic first, input logic last, input rsel_t dst);
    uop_t u;
    u.a = a;
    u.b = b;
    u.neg = neg;
    u.first = first;
    u.last = last;
    u.dst = dst;
    return u;
  endfunction

  // Sequence of multiply-accumulate terms: h = d x e2, a = e1.h, un = s.h,
  // q = s x e1, vn = d.q, tn = e2.q.
  function automatic uop_t uop_at(input logic [STEP_W-1:0] idx);
    uop_t u;
    case (idx)
      5'd0:  u = mk(A_D1, B_E22, 1'b0, 1'b1, 1'b0, R_H0);
      5'd1:  u = mk(A_D2, B_E21, 1'b1, 1'b0, 1'b1, R_H0);
      5'd2:  u = mk(A_D2, B_E20, 1'b0, 1'b1, 1'b0, R_H1);
      5'd3:  u = mk(A_D0, B_E22, 1'b1, 1'b0, 1'b1, R_H1);
      5'd4:  u = mk(A_D0, B_E21, 1'b0, 1'b1, 1'b0, R_H2);
      5'd5:  u = mk(A_D1, B_E20, 1'b1, 1'b0, 1'b1, R_H2);
      5'd6:  u = mk(A_H0, B_E10, 1'b0, 1'b1, 1'b0, R_A);
      5'd7:  u = mk(A_H1, B_E11, 1'b0, 1'b0, 1'b0, R_A);
      5'd8:  u = mk(A_H2, B_E12, 1'b0, 1'b0, 1'b1, R_A);
      5'd9:  u = mk(A_H0, B_S0,  1'b0, 1'b1, 1'b0, R_UN);
      5'd10: u = mk(A_H1, B_S1,  1'b0, 1'b0, 1'b0, R_UN);
      5'd11: u = mk(A_H2, B_S2,  1'b0, 1'b0, 1'b1, R_UN);
      5'd12: u = mk(A_S1, B_E12, 1'b0, 1'b1, 1'b0, R_Q0);
      5'd13: u = mk(A_S2, B_E11, 1'b1, 1'b0, 1'b1, R_Q0);
      5'd14: u = mk(A_S2, B_E10, 1'b0, 1'b1, 1'b0, R_Q1);
      5'd15: u = mk(A_S0, B_E12, 1'b1, 1'b0, 1'b1, R_Q1);
      5'd16: u = mk(A_S0, B_E11, 1'b0, 1'b1, 1'b0, R_Q2);
      5'd17: u = mk(A_S1, B_E10, 1'b1, 1'b0, 1'b1, R_Q2);
      5'd18: u = mk(A_Q0, B_D0,  1'b0, 1'b1, 1'b0, R_VN);
      5'd19: u = mk(A_Q1, B_D1,  1'b0, 1'b0, 1'b0, R_VN);
      5'd20: u = mk(A_Q2, B_D2,  1'b0, 1'b0, 1'b1, R_VN);
      5'd21: u = mk(A_Q0, B_E20, 1'b0, 1'b1, 1'b0, R_TN);
      5'd22: u = mk(A_Q1, B_E21, 1'b0, 1'b0, 1'b0, R_TN);
      5'd23: u = mk(A_Q2, B_E22, 1'b0, 1'b0, 1'b1, R_TN);
      default: u = mk(A_D0, B_D0, 1'b0, 1'b1, 1'b0, R_A);
    endcase
    return u;
  endfunction

endpackage

FILE: sv/rtc_mac.sv
module rtc_mac #(
  parameter int OPA_W = 102,
  parameter int OPB_W = 33
) (
  input  logic                clk,
  input  logic                rst,
  input  rtc_pkg::mac_ctl_t   ctl,
  input  logic [OPA_W-1:0]    opa,
  input  logic [OPB_W-1:0]    opb,
  output logic                busy,
  output logic [OPA_W-1:0]    acc
);
  import rtc_pkg::*;

  localparam int CNT_W = $clog2(OPB_W + 1);

  logic [OPA_W-1:0] ma;
  logic [OPB_W-1:0] mb;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [OPA_W-1:0] term;
  logic             top_bit;

  assign term    = mb[0] ? ma : '0;
  assign top_bit = (cnt == CNT_W'(OPB_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy && top_bit) begin
      busy <= 1'b0;
    end
    if (ctl.start) begin
      ma  <= opa;
      mb  <= opb;
      cnt <= '0;
      neg <= ctl.neg;
      if (ctl.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (neg ^ top_bit) begin
        acc <= acc - term;
      end else begin
        acc <= acc + term;
      end
      ma  <= ma << 1;
      mb  <= mb >> 1;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

FILE: sv/rtc_div.sv
module rtc_div #(
  parameter int NUM_W = 118,
  parameter int DEN_W = 102
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  import rtc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [NUM_W-1:0] nreg;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem, nreg[NUM_W-1]};
  assign diff    = shifted - {1'b0, dreg};
  assign ge      = !diff[DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(NUM_W - 1)) begin
      busy <= 1'b0;
    end
    if (start) begin
      rem  <= '0;
      dreg <= den;
      nreg <= num;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      nreg <= nreg << 1;
      quo  <= {quo[NUM_W-2:0], ge};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

FILE: sv/ray_triangle_closest_hit_top.sv
// Moller-Trumbore ray/triangle tester with closest-hit tracking. The ray, t_near and
// t_far sit in configuration registers; each input beat is one triangle and yields one
// output beat with this triangle's saturated t, whether it became the new closest hit,
// and the kept closest t and index. All products are formed exactly by one shared
// bit-serial multiply-accumulate unit running 24 terms, and t comes from a restoring
// divider, which a rejected triangle skips. The result t is in Q16.16 at the
// default widths. The block takes no new triangle until the output beat has been taken.
module ray_triangle_closest_hit_top #(
  parameter int COORD_WIDTH = rtc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rtc_pkg::FRAC_BITS_DEF,
  parameter int INDEX_WIDTH = rtc_pkg::INDEX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, tri_id, zero fill.
  input  logic [((9*COORD_WIDTH+INDEX_WIDTH+7)/8)*8-1:0] s_tdata,
  // restart.
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // this_hit, this_t, best_found, best_t, best_id, zero fill.
  output logic [((2*COORD_WIDTH+INDEX_WIDTH+2+7)/8)*8-1:0] m_tdata
);
  import rtc_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int D     = W + 1;
  localparam int H_W   = 2 * D + 1;
  localparam int ACC_W = 3 * D + 3;
  localparam int NUM_W = ACC_W + FRAC_BITS;
  localparam int OUT_W = 2 * W + INDEX_WIDTH + 2;
  localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8 - OUT_W;

  localparam logic [W-1:0]     T_MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]     T_MINN = {1'b1, {(W-1){1'b0}}};
  localparam logic [NUM_W-1:0] Q_MAXP = {{(NUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NUM_W-1:0] Q_MINM = {{(NUM_W-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MULW, S_CHK, S_TEST, S_DIVW, S_SAT, S_UPD, S_OUT
  } state_t;

  state_t state;

  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dirv [3];
  logic signed [W-1:0] t_near;
  logic signed [W-1:0] t_far;

  logic signed [D-1:0] vd [3];
  logic signed [D-1:0] ve1 [3];
  logic signed [D-1:0] ve2 [3];
  logic signed [D-1:0] vs [3];
  logic signed [H_W-1:0] vh [3];
  logic signed [H_W-1:0] vq [3];
  logic signed [ACC_W-1:0] va, vun, vvn, vtn;

  logic [INDEX_WIDTH-1:0] tri_id;
  logic [STEP_W-1:0]      step;
  logic                   tneg;
  logic                   this_hit;
  logic signed [W-1:0]    this_t;
  logic                   best_found;
  logic signed [W-1:0]    best_t;
  logic [INDEX_WIDTH-1:0] best_id;

  uop_t             uop;
  mac_ctl_t         mac_ctl;
  logic [ACC_W-1:0] opa;
  logic [D-1:0]     opb;
  logic             mac_busy;
  logic [ACC_W-1:0] mac_acc;
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic             div_busy;
  logic [NUM_W-1:0] div_quo;
  logic [ACC_W-1:0] tn_mag;
  logic signed [ACC_W:0] uv_sum;
  logic             bary_ok;

  logic signed [W-1:0] in_v [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      in_v[k] = s_tdata[k*W +: W];
    end
  end

  assign uop = uop_at(step);

  always_comb begin
    case (uop.a)
      A_D0: opa = {{(ACC_W-D){vd[0][D-1]}}, vd[0]};
      A_D1: opa = {{(ACC_W-D){vd[1][D-1]}}, vd[1]};
      A_D2: opa = {{(ACC_W-D){vd[2][D-1]}}, vd[2]};
      A_S0: opa = {{(ACC_W-D){vs[0][D-1]}}, vs[0]};
      A_S1: opa = {{(ACC_W-D){vs[1][D-1]}}, vs[1]};
      A_S2: opa = {{(ACC_W-D){vs[2][D-1]}}, vs[2]};
      A_H0: opa = {{(ACC_W-H_W){vh[0][H_W-1]}}, vh[0]};
      A_H1: opa = {{(ACC_W-H_W){vh[1][H_W-1]}}, vh[1]};
      A_H2: opa = {{(ACC_W-H_W){vh[2][H_W-1]}}, vh[2]};
      A_Q0: opa = {{(ACC_W-H_W){vq[0][H_W-1]}}, vq[0]};
      A_Q1: opa = {{(ACC_W-H_W){vq[1][H_W-1]}}, vq[1]};
      A_Q2: opa = {{(ACC_W-H_W){vq[2][H_W-1]}}, vq[2]};
      default: opa = '0;
    endcase
    case (uop.b)
      B_D0:  opb = vd[0];
      B_D1:  opb = vd[1];
      B_D2:  opb = vd[2];
      B_E10: opb = ve1[0];
      B_E11: opb = ve1[1];
      B_E12: opb = ve1[2];
      B_E20: opb = ve2[0];
      B_E21: opb = ve2[1];
      B_E22: opb = ve2[2];
      B_S0:  opb = vs[0];
      B_S1:  opb = vs[1];
      B_S2:  opb = vs[2];
      default: opb = '0;
    endcase
  end

  assign mac_ctl.start = (state == S_MUL);
  assign mac_ctl.clear = uop.first;
  assign mac_ctl.neg   = uop.neg;

  rtc_mac #(.OPA_W(ACC_W), .OPB_W(D)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .opa  (opa),
    .opb  (opb),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  assign tn_mag  = vtn[ACC_W-1] ? -vtn : vtn;
  assign div_num = {tn_mag, {FRAC_BITS{1'b0}}};
  assign uv_sum  = {vun[ACC_W-1], vun} + {vvn[ACC_W-1], vvn};
  assign bary_ok = !vun[ACC_W-1] && !(vun > va) && !vvn[ACC_W-1] &&
                   !(uv_sum > {va[ACC_W-1], va});
  assign div_start = (state == S_TEST) && bary_ok;

  rtc_div #(.NUM_W(NUM_W), .DEN_W(ACC_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (va),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata   = {{OUT_PAD{1'b0}}, best_id, best_t, best_found, this_t, this_hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      for (int k = 0; k < 3; k++) begin
        org[k]  <= '0;
        dirv[k] <= '0;
      end
      t_near     <= '0;
      t_far      <= T_MAXP;
      best_t     <= T_MAXP;
      best_found <= 1'b0;
      best_id    <= '0;
      step       <= '0;
      this_hit   <= 1'b0;
      this_t     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ORIGIN_X: org[0]  <= cfg_data;
          REG_ORIGIN_Y: org[1]  <= cfg_data;
          REG_ORIGIN_Z: org[2]  <= cfg_data;
          REG_DIR_X:    dirv[0] <= cfg_data;
          REG_DIR_Y:    dirv[1] <= cfg_data;
          REG_DIR_Z:    dirv[2] <= cfg_data;
          REG_T_NEAR:   t_near  <= cfg_data;
          REG_T_FAR:    t_far   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int k = 0; k < 3; k++) begin
              vd[k]  <= {dirv[k][W-1], dirv[k]};
              ve1[k] <= {in_v[3+k][W-1], in_v[3+k]} - {in_v[k][W-1], in_v[k]};
              ve2[k] <= {in_v[6+k][W-1], in_v[6+k]} - {in_v[k][W-1], in_v[k]};
              vs[k]  <= {org[k][W-1], org[k]} - {in_v[k][W-1], in_v[k]};
            end
            tri_id   <= s_tdata[9*W +: INDEX_WIDTH];
            this_hit <= 1'b0;
            this_t   <= '0;
            step     <= '0;
            if (s_tuser) begin
              best_t     <= t_far;
              best_found <= 1'b0;
              best_id    <= '0;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_MULW;
        end
        S_MULW: begin
          if (!mac_busy) begin
            if (uop.last) begin
              case (uop.dst)
                R_H0: vh[0] <= mac_acc[H_W-1:0];
                R_H1: vh[1] <= mac_acc[H_W-1:0];
                R_H2: vh[2] <= mac_acc[H_W-1:0];
                R_Q0: vq[0] <= mac_acc[H_W-1:0];
                R_Q1: vq[1] <= mac_acc[H_W-1:0];
                R_Q2: vq[2] <= mac_acc[H_W-1:0];
                R_A:  va    <= mac_acc;
                R_UN: vun   <= mac_acc;
                R_VN: vvn   <= mac_acc;
                R_TN: vtn   <= mac_acc;
                default: ;
              endcase
            end
            if (step == STEP_W'(NUM_UOPS - 1)) begin
              state <= S_CHK;
            end else begin
              step  <= step + 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_CHK: begin
          if (va == '0) begin
            state <= S_OUT;
          end else begin
            if (va[ACC_W-1]) begin
              va  <= -va;
              vun <= -vun;
              vvn <= -vvn;
              vtn <= -vtn;
            end
            state <= S_TEST;
          end
        end
        S_TEST: begin
          tneg  <= vtn[ACC_W-1];
          state <= bary_ok ? S_DIVW : S_OUT;
        end
        S_DIVW: begin
          if (!div_busy) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (tneg) begin
            this_t <= (div_quo > Q_MINM) ? T_MINN : -div_quo[W-1:0];
          end else begin
            this_t <= (div_quo > Q_MAXP) ? T_MAXP : div_quo[W-1:0];
          end
          state <= S_UPD;
        end
        S_UPD: begin
          if (this_t > t_near && this_t < best_t) begin
            best_t     <= this_t;
            best_found <= 1'b1;
            best_id    <= tri_id;
            this_hit   <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/ray_triangle_closest_hit_top_tb.sv
`timescale 1ns / 100ps

module ray_triangle_closest_hit_top_tb;
  import rtc_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int IW = INDEX_WIDTH_DEF;
  localparam int ONE = 65536;
  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int TOTAL_RANDOM = 2000;

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic [IW-1:0] tri_id;
    logic [CW-1:0] v2_z, v2_y, v2_x, v1_z, v1_y, v1_x, v0_z, v0_y, v0_x;
  } triangle_t;

  typedef struct packed {
    logic [5:0]    fill;
    logic [IW-1:0] best_id;
    logic [CW-1:0] best_t;
    logic          best_found;
    logic [CW-1:0] this_t;
    logic          this_hit;
  } hit_report_t;

  class hit_scoreboard;
    logic [CW-1:0] ray_regs[8];
    logic [CW-1:0] closest_t;
    logic          found;
    logic [IW-1:0] closest_id;
    hit_report_t   expected_hits[$];
    int            errors;

    function new();
      foreach (ray_regs[i]) ray_regs[i] = '0;
      ray_regs[REG_T_FAR] = {1'b0, {(CW-1){1'b1}}};
      closest_t = ray_regs[REG_T_FAR];
      found = 1'b0;
      closest_id = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CW-1:0] value);
      ray_regs[idx] = value;
    endfunction

    function wide_t ext(logic [CW-1:0] x);
      return wide_t'(signed'(x));
    endfunction

    function void note_triangle(triangle_t tr, logic restart);
      wide_t o[3], d[3], p0[3], e1[3], e2[3], s[3], h[3], q[3];
      wide_t det, un, vn, tn, tq;
      logic [159:0] mag;
      hit_report_t r;
      logic hit;
      logic [CW-1:0] traw;
      o[0] = ext(ray_regs[REG_ORIGIN_X]); o[1] = ext(ray_regs[REG_ORIGIN_Y]);
      o[2] = ext(ray_regs[REG_ORIGIN_Z]);
      d[0] = ext(ray_regs[REG_DIR_X]); d[1] = ext(ray_regs[REG_DIR_Y]);
      d[2] = ext(ray_regs[REG_DIR_Z]);
      p0[0] = ext(tr.v0_x); p0[1] = ext(tr.v0_y); p0[2] = ext(tr.v0_z);
      e1[0] = ext(tr.v1_x) - p0[0]; e1[1] = ext(tr.v1_y) - p0[1];
      e1[2] = ext(tr.v1_z) - p0[2];
      e2[0] = ext(tr.v2_x) - p0[0]; e2[1] = ext(tr.v2_y) - p0[1];
      e2[2] = ext(tr.v2_z) - p0[2];
      for (int i = 0; i < 3; i++) s[i] = o[i] - p0[i];
      if (restart) begin
        closest_t = ray_regs[REG_T_FAR];
        found = 1'b0;
        closest_id = '0;
      end
      hit = 1'b0;
      traw = '0;
      h[0] = d[1] * e2[2] - d[2] * e2[1];
      h[1] = d[2] * e2[0] - d[0] * e2[2];
      h[2] = d[0] * e2[1] - d[1] * e2[0];
      det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
      if (det != 0) begin
        un = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (det < 0) begin
          det = -det; un = -un; vn = -vn; tn = -tn;
        end
        if (!(un < 0 || un > det || vn < 0 || un + vn > det)) begin
          mag = (tn < 0) ? -tn : tn;
          mag = mag << 16;
          tq = wide_t'(mag / det);
          if (tn < 0) tq = -tq;
          if (tq > ext({1'b0, {(CW-1){1'b1}}})) tq = ext({1'b0, {(CW-1){1'b1}}});
          if (tq < ext({1'b1, {(CW-1){1'b0}}})) tq = ext({1'b1, {(CW-1){1'b0}}});
          traw = tq[CW-1:0];
          if (tq > ext(ray_regs[REG_T_NEAR]) && tq < ext(closest_t)) begin
            closest_t = traw;
            found = 1'b1;
            closest_id = tr.tri_id;
            hit = 1'b1;
          end
        end
      end
      r = '0;
      r.this_hit = hit;
      r.this_t = traw;
      r.best_found = found;
      r.best_t = closest_t;
      r.best_id = closest_id;
      expected_hits.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(hit_report_t got);
      hit_report_t want;
      if (expected_hits.size() == 0) begin
        report("output beat with nothing expected");
      end else begin
        want = expected_hits.pop_front();
        if (got.this_hit !== want.this_hit)
          report($sformatf("this_hit %0b, expected %0b", got.this_hit, want.this_hit));
        if (got.this_t !== want.this_t)
          report($sformatf("this_t %h, expected %h", got.this_t, want.this_t));
        if (got.best_found !== want.best_found)
          report($sformatf("best_found %0b, expected %0b", got.best_found, want.best_found));
        if (got.best_t !== want.best_t)
          report($sformatf("best_t %h, expected %h", got.best_t, want.best_t));
        if (got.best_id !== want.best_id)
          report($sformatf("best_id %h, expected %h", got.best_id, want.best_id));
      end
    endtask
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  logic s_tvalid, s_tready, s_tuser;
  logic [311:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [95:0] m_tdata;

  hit_scoreboard sb;
  bit idling_on;
  longint cycles;

  ray_triangle_closest_hit_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready) sb.note_triangle(triangle_t'(s_tdata), s_tuser);
      if (m_tvalid && m_tready) sb.check_result(hit_report_t'(m_tdata));
    end
  end

  initial begin
    m_tready <= 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_ray(logic [CW-1:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_triangle(triangle_t tr, logic restart);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= tr;
    s_tuser <= restart;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic triangle_t flat_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                                         int z, int id);
    triangle_t t;
    t.v0_x = x0 * (ONE / 2); t.v0_y = y0 * (ONE / 2); t.v0_z = z * (ONE / 2);
    t.v1_x = x1 * (ONE / 2); t.v1_y = y1 * (ONE / 2); t.v1_z = z * (ONE / 2);
    t.v2_x = x2 * (ONE / 2); t.v2_y = y2 * (ONE / 2); t.v2_z = z * (ONE / 2);
    t.tri_id = IW'(id);
    return t;
  endfunction

  function automatic triangle_t noise_tri();
    triangle_t t;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, 24'($urandom)};
    return t;
  endfunction

  function automatic int signed_span(int bits);
    int m;
    m = $urandom_range(0, (1 << bits) - 1);
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  function automatic triangle_t aimed_tri(logic [CW-1:0] ray[8]);
    triangle_t t;
    int k, r;
    logic [CW-1:0] c[3], v[9];
    k = $urandom_range(0, 7) == 0 ? -$urandom_range(1, 50) : $urandom_range(0, 200);
    for (int i = 0; i < 3; i++) c[i] = ray[REG_ORIGIN_X + i] + ray[REG_DIR_X + i] * k;
    r = $urandom_range(4, 24);
    for (int j = 0; j < 9; j++) v[j] = c[j % 3] + signed_span(r);
    t.v0_x = v[0]; t.v0_y = v[1]; t.v0_z = v[2];
    t.v1_x = v[3]; t.v1_y = v[4]; t.v1_z = v[5];
    t.v2_x = v[6]; t.v2_y = v[7]; t.v2_z = v[8];
    t.tri_id = IW'($urandom);
    return t;
  endfunction

  initial begin
    logic [CW-1:0] ray[8];
    triangle_t t;
    int phase_items;
    sb = new();
    clk = 1'b0;
    cycles = 0;
    idling_on = 1'b1;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ORIGIN_X;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    ray = '{0, 0, 0, 0, 0, ONE, 0, 32'h7fffffff};
    write_ray(ray);
    send_triangle(flat_tri(-2, -2, 4, -2, -2, 4, 10, 1), 1'b0);
    send_triangle(flat_tri(-2, -2, 4, -2, -2, 4, 16, 2), 1'b0);
    send_triangle(flat_tri(-2, -2, 4, -2, -2, 4, 6, 3), 1'b0);
    send_triangle(flat_tri(-2, -2, 4, -2, -2, 4, 6, 4), 1'b0);
    send_triangle(flat_tri(-2, -2, 4, -2, -2, 4, -4, 5), 1'b0);
    send_triangle(flat_tri(2, -2, 6, -2, 2, 2, 4, 6), 1'b0);
    send_triangle(flat_tri(-2, 2, 2, 2, -2, 6, 4, 7), 1'b0);
    send_triangle(flat_tri(-4, -4, 2, -4, -4, 2, 4, 8), 1'b0);
    t = flat_tri(0, 0, 0, 2, 0, 0, 0, 9);
    t.v2_z = 2 * ONE;
    send_triangle(t, 1'b0);
    send_triangle(flat_tri(-2, -2, 4, -2, -2, 4, 16, 24'hffffff), 1'b1);
    send_triangle({{9{32'h7fffffff}}, 24'hffffff}, 1'b0);
    send_triangle({{9{32'h80000000}}, 24'h000000}, 1'b1);
    send_triangle(noise_tri(), 1'b0);
    drain();
    ray = '{0, 0, 0, 0, 0, 1, 32'h80000000, 32'h80000000};
    write_ray(ray);
    send_triangle(flat_tri(-2, -2, 4, -2, -2, 4, 2, 10), 1'b1);
    send_triangle(flat_tri(-2, -2, 4, -2, -2, 4, -2, 11), 1'b0);
    ray = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff, 32'h7fffffff};
    drain();
    write_ray(ray);
    send_triangle(noise_tri(), 1'b1);
    send_triangle(aimed_tri(ray), 1'b0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < 3; i++) begin
        ray[REG_ORIGIN_X + i] = signed_span($urandom_range(8, 26));
        ray[REG_DIR_X + i] = $urandom_range(0, 5) == 0 ? 0 : signed_span($urandom_range(4, 20));
      end
      ray[REG_T_NEAR] = $urandom_range(0, 1) ? 0 : signed_span($urandom_range(4, 24));
      ray[REG_T_FAR] = $urandom_range(0, 1) ? 32'h7fffffff : $urandom_range(ONE, 150 * ONE);
      write_ray(ray);
      phase_items = TOTAL_RANDOM / 6;
      if (phase == 5) idling_on = 1'b0;
      for (int n = 0; n < phase_items; n++) begin
        if ($urandom_range(0, 4) == 0) t = noise_tri();
        else t = aimed_tri(ray);
        send_triangle(t, $urandom_range(0, 9) == 0);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.expected_hits.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_hits.size()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rtc_pkg.sv
sv/rtc_mac.sv
sv/rtc_div.sv
sv/ray_triangle_closest_hit_top.sv
tb/ray_triangle_closest_hit_top_tb.sv
